FILE: hw/rtl/ctvc_pkg.sv
package ctvc_pkg;

	// Register map, word index on the configuration port
	typedef enum logic [2:0] {
		REG_RADIUS = 3'd0,
		REG_SPEED  = 3'd1,
		REG_RATE   = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_GAIN   = 3'd4
	} reg_idx_t;

	// Quadrant of the phase, top two bits
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	localparam int ATAN_LEN = 24;
	localparam int TRIG_W   = 34;
	localparam int SAT_W    = 68;

	localparam logic signed [TRIG_W-1:0] CORDIC_K = 34'sd652032874;
	localparam logic signed [32:0] ONE_Q27 = 33'sd134217728;

	// atan(2^-i) in Q0.32 turns
	localparam logic signed [31:0] ATAN_TURNS [ATAN_LEN] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81
	};

	typedef struct packed {
		logic [30:0]        radius;
		logic [30:0]        speed;
		logic [31:0]        rate;
		logic signed [31:0] height;
		logic [23:0]        gain;
	} cfg_t;

	// Fields that ride along the trig pipeline
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic [1:0]         quad;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -68'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

FILE: hw/rtl/ctvc_if.sv
interface ctvc_in_if;
	logic               valid;
	logic               ready;
	logic [31:0]        elapsed_time;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;

	modport source (output valid, elapsed_time, pos_x, pos_y, pos_z,
		quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, elapsed_time, pos_x, pos_y, pos_z,
		quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface ctvc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vel_body_x;
	logic signed [31:0] vel_body_y;
	logic signed [31:0] vel_body_z;

	modport source (output valid, vel_body_x, vel_body_y, vel_body_z, input ready);
	modport sink (input valid, vel_body_x, vel_body_y, vel_body_z, output ready);
endinterface

FILE: hw/rtl/ctvc_cfg.sv
module ctvc_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ctvc_pkg::cfg_t    cfg
);
	import ctvc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register, drop bits above its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= 31'd393216;
			cfg_q.speed  <= 31'd131072;
			cfg_q.rate   <= 32'd890059;
			cfg_q.height <= 32'sd196608;
			cfg_q.gain   <= 24'd6554;
		end else if (wr) begin
			case (idx)
				REG_RADIUS: cfg_q.radius <= pwdata[30:0];
				REG_SPEED:  cfg_q.speed  <= pwdata[30:0];
				REG_RATE:   cfg_q.rate   <= pwdata;
				REG_HEIGHT: cfg_q.height <= $signed(pwdata);
				REG_GAIN:   cfg_q.gain   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_RADIUS: prdata = {1'b0, cfg_q.radius};
			REG_SPEED:  prdata = {1'b0, cfg_q.speed};
			REG_RATE:   prdata = cfg_q.rate;
			REG_HEIGHT: prdata = cfg_q.height;
			REG_GAIN:   prdata = {8'd0, cfg_q.gain};
			default:    prdata = 32'd0;
		endcase
	end
endmodule

FILE: hw/rtl/ctvc_cordic.sv
module ctvc_cordic #(
	parameter int ITER = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [31:0]                           in_phase,
	input  ctvc_pkg::side_t                       in_side,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ctvc_pkg::TRIG_W-1:0]    out_x,
	output logic signed [ctvc_pkg::TRIG_W-1:0]    out_y,
	output ctvc_pkg::side_t                       out_side
);
	import ctvc_pkg::*;

	logic                     v_sn    [ITER+1];
	logic                     en_sn   [ITER+2];
	logic signed [TRIG_W-1:0] x_sn    [ITER+1];
	logic signed [TRIG_W-1:0] y_sn    [ITER+1];
	logic signed [31:0]       z_sn    [ITER+1];
	side_t                    side_sn [ITER+1];

	// Stage enables: a stage moves when it is empty or the next one moves
	always_comb begin
		en_sn[ITER+1] = out_ready;
		for (int i = ITER; i >= 0; i--)
			en_sn[i] = !v_sn[i] || en_sn[i+1];
	end

	assign in_ready  = en_sn[0];
	assign out_valid = v_sn[ITER];
	assign out_x     = x_sn[ITER];
	assign out_y     = y_sn[ITER];
	assign out_side  = side_sn[ITER];

	// Load the start vector, angle below a quarter turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sn[0] <= 1'b0;
		else if (en_sn[0])
			v_sn[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_sn[0]) begin
			x_sn[0]    <= CORDIC_K;
			y_sn[0]    <= '0;
			z_sn[0]    <= $signed({2'b00, in_phase[29:0]});
			side_sn[0] <= in_side;
		end
	end

	// One rotation step per stage
	for (genvar i = 0; i < ITER; i++) begin : g_step
		logic signed [TRIG_W-1:0] dx;
		logic signed [TRIG_W-1:0] dy;
		assign dx = y_sn[i] >>> i;
		assign dy = x_sn[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sn[i+1] <= 1'b0;
			else if (en_sn[i+1])
				v_sn[i+1] <= v_sn[i];
		end

		always_ff @(posedge clk) begin
			if (en_sn[i+1]) begin
				if (!z_sn[i][31]) begin
					x_sn[i+1] <= x_sn[i] - dx;
					y_sn[i+1] <= y_sn[i] + dy;
					z_sn[i+1] <= z_sn[i] - ATAN_TURNS[i];
				end else begin
					x_sn[i+1] <= x_sn[i] + dx;
					y_sn[i+1] <= y_sn[i] - dy;
					z_sn[i+1] <= z_sn[i] + ATAN_TURNS[i];
				end
				side_sn[i+1] <= side_sn[i];
			end
		end
	end

	// Residual angle stays inside a quarter turn either way
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_sn[ITER] |-> (z_sn[ITER] < 32'sd1073741824 && z_sn[ITER] > -32'sd1073741824))
		else $error("cordic residual angle out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_sn[ITER] && !out_ready |=> v_sn[ITER] && $stable(x_sn[ITER]))
		else $error("cordic output lost under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_sn[0] |-> in_ready)
		else $error("cordic refuses input while first stage empty");
endmodule

FILE: hw/rtl/circle_tracking_velocity_command.sv
// Circle-tracking velocity command.
// sample (valid/ready) carries elapsed time, world position and attitude
// quaternion; command (valid/ready) returns the body frame velocity command,
// one transaction out for each transaction in, in order.
// The target lies on a horizontal circle set by the APB registers (radius,
// speed, turn rate, height, gain). Write them only while the pipeline is empty.
// Throughput: one transaction per cycle while the command receiver does not stall.
// Accepted transactions pass the phase stage, the CORDIC load stage, one
// pipelined CORDIC stage per step, then the multiply, round and rotate stages.
// Each stage holds while the one after it is full and stalled, so a stalled
// command receiver backs the pipeline up; bubbles still close up and sample
// stays ready while any stage has room. Nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults
// (radius 6.0, speed 2.0, height 3.0, gain 0.1).
module circle_tracking_velocity_command #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ctvc_in_if.sink     sample,
	ctvc_out_if.source  command,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ctvc_pkg::*;

	cfg_t cfg;

	ctvc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;
	logic cor_in_ready, cor_valid;

	// Stage enables
	assign en_s8 = !v_s8 || command.ready;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || cor_in_ready;
	assign sample.ready = en_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample.valid;
			if (en_s2) v_s2 <= cor_valid;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// Stage 1: phase in turns, whole turns dropped
	logic [63:0] phase_prod;
	logic [31:0] phase_s1;
	side_t       side_s1;
	assign phase_prod = 64'(sample.elapsed_time) * 64'(cfg.rate);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			phase_s1       <= phase_prod[39:8];
			side_s1.pos_x  <= sample.pos_x;
			side_s1.pos_y  <= sample.pos_y;
			side_s1.pos_z  <= sample.pos_z;
			side_s1.quat_w <= sample.quat_w;
			side_s1.quat_x <= sample.quat_x;
			side_s1.quat_y <= sample.quat_y;
			side_s1.quat_z <= sample.quat_z;
			side_s1.quad   <= phase_prod[39:38];
		end
	end

	logic signed [TRIG_W-1:0] cor_x, cor_y;
	side_t                    cor_side;

	ctvc_cordic #(
		.ITER (TRIG_ITERATIONS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cor_in_ready),
		.in_phase  (phase_s1),
		.in_side   (side_s1),
		.out_valid (cor_valid),
		.out_ready (en_s2),
		.out_x     (cor_x),
		.out_y     (cor_y),
		.out_side  (cor_side)
	);

	// Stage 2: quadrant unfold, quaternion products
	logic signed [TRIG_W-1:0] cos_s2, sin_s2;
	logic signed [31:0]       px_s2, py_s2, pz_s2;
	logic signed [31:0]       xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2, wx_s2, wy_s2, wz_s2;
	logic signed [TRIG_W-1:0] cos_d, sin_d;

	always_comb begin
		case (quad_t'(cor_side.quad))
			QUAD_0: begin cos_d = cor_x;  sin_d = cor_y;  end
			QUAD_1: begin cos_d = -cor_y; sin_d = cor_x;  end
			QUAD_2: begin cos_d = -cor_x; sin_d = -cor_y; end
			default: begin cos_d = cor_y; sin_d = -cor_x; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cos_s2 <= cos_d;
			sin_s2 <= sin_d;
			px_s2  <= cor_side.pos_x;
			py_s2  <= cor_side.pos_y;
			pz_s2  <= cor_side.pos_z;
			xx_s2  <= 32'(cor_side.quat_x) * 32'(cor_side.quat_x);
			yy_s2  <= 32'(cor_side.quat_y) * 32'(cor_side.quat_y);
			zz_s2  <= 32'(cor_side.quat_z) * 32'(cor_side.quat_z);
			xy_s2  <= 32'(cor_side.quat_x) * 32'(cor_side.quat_y);
			xz_s2  <= 32'(cor_side.quat_x) * 32'(cor_side.quat_z);
			yz_s2  <= 32'(cor_side.quat_y) * 32'(cor_side.quat_z);
			wx_s2  <= 32'(cor_side.quat_w) * 32'(cor_side.quat_x);
			wy_s2  <= 32'(cor_side.quat_w) * 32'(cor_side.quat_y);
			wz_s2  <= 32'(cor_side.quat_w) * 32'(cor_side.quat_z);
		end
	end

	// Stage 3: radius and speed times cos/sin, rotation matrix in Q.27
	logic signed [65:0] rc_s3, rs_s3, sc_s3, ss_s3;
	logic signed [31:0] px_s3, py_s3, pz_s3;
	logic signed [32:0] m_s3 [3][3];
	logic signed [32:0] radius_sx, speed_sx;

	assign radius_sx = $signed({2'b00, cfg.radius});
	assign speed_sx  = $signed({2'b00, cfg.speed});

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rc_s3 <= 66'(radius_sx) * 66'(cos_s2);
			rs_s3 <= 66'(radius_sx) * 66'(sin_s2);
			sc_s3 <= 66'(speed_sx) * 66'(cos_s2);
			ss_s3 <= 66'(speed_sx) * 66'(sin_s2);
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			pz_s3 <= pz_s2;
			m_s3[0][0] <= ONE_Q27 - (33'(yy_s2) + 33'(zz_s2));
			m_s3[0][1] <= 33'(xy_s2) + 33'(wz_s2);
			m_s3[0][2] <= 33'(xz_s2) - 33'(wy_s2);
			m_s3[1][0] <= 33'(xy_s2) - 33'(wz_s2);
			m_s3[1][1] <= ONE_Q27 - (33'(xx_s2) + 33'(zz_s2));
			m_s3[1][2] <= 33'(yz_s2) + 33'(wx_s2);
			m_s3[2][0] <= 33'(xz_s2) + 33'(wy_s2);
			m_s3[2][1] <= 33'(yz_s2) - 33'(wx_s2);
			m_s3[2][2] <= ONE_Q27 - (33'(xx_s2) + 33'(yy_s2));
		end
	end

	// Stage 4: round to Q16.16, position error
	logic signed [65:0] half30;
	logic signed [35:0] tx, ty, fx, fy;
	logic signed [36:0] ex_s4, ey_s4, ez_s4, fx_s4, fy_s4;
	logic signed [32:0] m_s4 [3][3];

	assign half30 = 66'sd1 <<< 29;
	assign tx = 36'((rc_s3 + half30) >>> 30);
	assign ty = 36'((rs_s3 + half30) >>> 30);
	assign fx = 36'((ss_s3 + half30) >>> 30);
	assign fy = 36'((sc_s3 + half30) >>> 30);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ex_s4 <= 37'(tx) - 37'(px_s3);
			ey_s4 <= 37'(ty) - 37'(py_s3);
			ez_s4 <= 37'(cfg.height) - 37'(pz_s3);
			fx_s4 <= -37'(fx);
			fy_s4 <= 37'(fy);
			m_s4  <= m_s3;
		end
	end

	// Stage 5: gain times error
	logic signed [61:0] gx_s5, gy_s5, gz_s5;
	logic signed [36:0] fx_s5, fy_s5;
	logic signed [32:0] m_s5 [3][3];
	logic signed [24:0] gain_sx;

	assign gain_sx = $signed({1'b0, cfg.gain});

	always_ff @(posedge clk) begin
		if (en_s5) begin
			gx_s5 <= 62'(gain_sx) * 62'(ex_s4);
			gy_s5 <= 62'(gain_sx) * 62'(ey_s4);
			gz_s5 <= 62'(gain_sx) * 62'(ez_s4);
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			m_s5  <= m_s4;
		end
	end

	// Stage 6: round, add feedforward, saturate world command
	logic signed [61:0] half16;
	logic signed [46:0] wx_sum, wy_sum, wz_sum;
	logic signed [31:0] vw_s6 [3];
	logic signed [32:0] m_s6 [3][3];

	assign half16 = 62'sd1 <<< 15;
	assign wx_sum = 47'((gx_s5 + half16) >>> 16) + 47'(fx_s5);
	assign wy_sum = 47'((gy_s5 + half16) >>> 16) + 47'(fy_s5);
	assign wz_sum = 47'((gz_s5 + half16) >>> 16);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			vw_s6[0] <= sat32(SAT_W'(wx_sum));
			vw_s6[1] <= sat32(SAT_W'(wy_sum));
			vw_s6[2] <= sat32(SAT_W'(wz_sum));
			m_s6     <= m_s5;
		end
	end

	// Stage 7: matrix products, transposed rotation into body frame
	logic signed [64:0] p_s7 [3][3];

	always_ff @(posedge clk) begin
		if (en_s7) begin
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					p_s7[r][k] <= 65'(m_s6[r][k]) * 65'(vw_s6[k]);
		end
	end

	// Stage 8: exact sum, one rounding, saturate
	logic signed [SAT_W-1:0] half27;
	logic signed [SAT_W-1:0] dot [3];
	logic signed [31:0]      vel_s8 [3];

	assign half27 = 68'sd1 <<< 26;

	always_comb begin
		for (int r = 0; r < 3; r++)
			dot[r] = (SAT_W'(p_s7[r][0]) + SAT_W'(p_s7[r][1]) + SAT_W'(p_s7[r][2])
				+ half27) >>> 27;
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			for (int r = 0; r < 3; r++)
				vel_s8[r] <= sat32(dot[r]);
		end
	end

	assign command.valid      = v_s8;
	assign command.vel_body_x = vel_s8[0];
	assign command.vel_body_y = vel_s8[1];
	assign command.vel_body_z = vel_s8[2];

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> sample.ready)
		else $error("input refused with first stage empty");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && !command.ready |=> v_s8 && $stable(vel_s8[0]) && $stable(vel_s8[2]))
		else $error("stalled command changed");
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s7 && !v_s8 |=> !v_s8)
		else $error("output stage filled from an empty stage");
endmodule

FILE: dv/circle_tracking_velocity_command_tb.sv
module circle_tracking_velocity_command_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ctvc_pkg::*;

	localparam int TRIG_ITER = 16;
	localparam int LATENCY = TRIG_ITER + 9;
	localparam int N_RANDOM = 1000;

	typedef struct {
		logic [31:0]        elapsed_time;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} pose_t;

	typedef struct {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} vel_t;

	// Expected velocity commands, in order of acceptance
	class velocity_scoreboard;
		vel_t pending_cmds[$];
		int errors;
		int checked;
		logic [30:0] radius;
		logic [30:0] speed;
		logic [31:0] rate;
		logic signed [31:0] height;
		logic [23:0] gain;

		function new();
			errors = 0;
			checked = 0;
			radius = 31'd393216;
			speed = 31'd131072;
			rate = 32'd890059;
			height = 32'sd196608;
			gain = 24'd6554;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_RADIUS: radius = v[30:0];
				REG_SPEED: speed = v[30:0];
				REG_RATE: rate = v;
				REG_HEIGHT: height = v;
				REG_GAIN: gain = v[23:0];
				default: ;
			endcase
		endfunction

		static function longint rnd_shift(longint v, int k);
			return (v + (longint'(1) << (k - 1))) >>> k;
		endfunction

		static function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		static function longint body_dot(longint a, longint va, longint b, longint vb,
			longint c, longint vc);
			longint p[3];
			longint hi, lo;
			hi = 0;
			lo = 0;
			p[0] = a * va;
			p[1] = b * vb;
			p[2] = c * vc;
			for (int k = 0; k < 3; k++) begin
				hi += p[k] >>> 27;
				lo += p[k] & 64'h7FFFFFF;
			end
			return clamp32(hi + ((lo + (longint'(1) << 26)) >>> 27));
		endfunction

		function vel_t predict(pose_t p);
			vel_t r;
			logic [63:0] prod;
			logic [31:0] phase;
			longint x, y, z, dx, dy, c, s, tx, ty, fx, fy, vx, vy, vz;
			longint qw, qx, qy, qz, xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
			prod = {32'd0, p.elapsed_time} * {32'd0, rate};
			phase = prod[39:8];
			x = longint'(CORDIC_K);
			y = 0;
			z = longint'(phase[29:0]);
			for (int i = 0; i < TRIG_ITER; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
				end else begin
					x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
				end
			end
			case (quad_t'(phase[31:30]))
				QUAD_0: begin c = x; s = y; end
				QUAD_1: begin c = -y; s = x; end
				QUAD_2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
			tx = rnd_shift(longint'(radius) * c, 30);
			ty = rnd_shift(longint'(radius) * s, 30);
			fx = -rnd_shift(longint'(speed) * s, 30);
			fy = rnd_shift(longint'(speed) * c, 30);
			vx = clamp32(rnd_shift(longint'(gain) * (tx - longint'(p.pos_x)), 16) + fx);
			vy = clamp32(rnd_shift(longint'(gain) * (ty - longint'(p.pos_y)), 16) + fy);
			vz = clamp32(rnd_shift(longint'(gain) * (longint'(height) - longint'(p.pos_z)),
				16));
			qw = longint'(p.quat_w); qx = longint'(p.quat_x);
			qy = longint'(p.quat_y); qz = longint'(p.quat_z);
			xx = qx * qx; yy = qy * qy; zz = qz * qz;
			xy = qx * qy; xz = qx * qz; yz = qy * qz;
			wx = qw * qx; wy = qw * qy; wz = qw * qz;
			one = longint'(1) << 27;
			r.vx = 32'(body_dot(one - (yy + zz), vx, xy + wz, vy, xz - wy, vz));
			r.vy = 32'(body_dot(xy - wz, vx, one - (xx + zz), vy, yz + wx, vz));
			r.vz = 32'(body_dot(xz + wy, vx, yz - wx, vy, one - (xx + yy), vz));
			return r;
		endfunction

		function void note_pose(pose_t p);
			pending_cmds.push_back(predict(p));
		endfunction

		function void check_command(vel_t got);
			vel_t e;
			checked++;
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected command x=%0d y=%0d z=%0d", $time, got.vx, got.vy,
					got.vz);
				errors++;
				return;
			end
			e = pending_cmds.pop_front();
			if (got.vx !== e.vx) begin
				$display("%0t: vel_body_x expected %0d actual %0d", $time, e.vx, got.vx);
				errors++;
			end
			if (got.vy !== e.vy) begin
				$display("%0t: vel_body_y expected %0d actual %0d", $time, e.vy, got.vy);
				errors++;
			end
			if (got.vz !== e.vz) begin
				$display("%0t: vel_body_z expected %0d actual %0d", $time, e.vz, got.vz);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ctvc_in_if sample();
	ctvc_out_if command();

	velocity_scoreboard sb = new();
	bit sender_idle_on = 1'b1;
	bit receiver_idle_on = 1'b1;
	int poses_sent = 0;
	int config_sets = 0;

	circle_tracking_velocity_command #(.TRIG_ITERATIONS(TRIG_ITER)) DUT (
		.clk(clk), .arst_n(arst_n), .sample(sample.sink), .command(command.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		sample.valid = 1'b0;
		sample.elapsed_time = '0;
		sample.pos_x = '0;
		sample.pos_y = '0;
		sample.pos_z = '0;
		sample.quat_w = '0;
		sample.quat_x = '0;
		sample.quat_y = '0;
		sample.quat_z = '0;
		command.ready = 1'b0;
	end

	// Write one register: setup cycle then access cycle
	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_reg(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_config(logic [31:0] rad, logic [31:0] spd, logic [31:0] rate,
		logic [31:0] hgt, logic [31:0] gn);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_SPEED, spd);
		write_reg(REG_RATE, rate);
		write_reg(REG_HEIGHT, hgt);
		write_reg(REG_GAIN, gn);
		config_sets++;
	endtask

	// Present one pose and hold it until the transaction completes
	task automatic send_pose(pose_t p);
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.elapsed_time <= p.elapsed_time;
		sample.pos_x <= p.pos_x;
		sample.pos_y <= p.pos_y;
		sample.pos_z <= p.pos_z;
		sample.quat_w <= p.quat_w;
		sample.quat_x <= p.quat_x;
		sample.quat_y <= p.quat_y;
		sample.quat_z <= p.quat_z;
		do @(posedge clk); while (sample.ready !== 1'b1);
		sb.note_pose(p);
		poses_sent++;
	endtask

	task automatic release_sample();
		sample.valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending_cmds.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_quat();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic [31:0] rand_wide();
		case ($urandom_range(0, 4))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(0, 1310720)) - 655360);
			default: return $urandom;
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		p.elapsed_time = $urandom;
		p.pos_x = rand_wide();
		p.pos_y = rand_wide();
		p.pos_z = rand_wide();
		p.quat_w = rand_quat();
		p.quat_x = rand_quat();
		p.quat_y = rand_quat();
		p.quat_z = rand_quat();
		return p;
	endfunction

	// Accept commands with random back pressure
	always @(posedge clk) begin
		if (command.valid === 1'b1 && command.ready === 1'b1)
			sb.check_command('{command.vel_body_x, command.vel_body_y, command.vel_body_z});
	end

	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				command.ready <= 1'b0;
			end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 13) - 1;
				command.ready <= 1'b0;
			end else
				command.ready <= 1'b1;
		end
	end

	initial begin
		pose_t p;
		logic signed [15:0] qv[4];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset settings, identity attitude, phase steps, field extremes
		p = '{32'd0, 32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0};
		send_pose(p);
		for (int q = 0; q < 4; q++) begin
			p.elapsed_time = 32'(q * 80000 + 1000);
			send_pose(p);
		end
		p = '{32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384};
		send_pose(p);
		p = '{32'h0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
		send_pose(p);
		qv = '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0};
		p = '{32'h12345678, 32'sd65536, -32'sd65536, 32'sd0, qv[0], qv[1], qv[2], qv[3]};
		send_pose(p);
		p.quat_w = 16'sd3; p.quat_x = 16'sd0; p.quat_y = 16'sd0; p.quat_z = 16'sd0;
		send_pose(p);
		release_sample();
		drain();

		// Extreme settings: largest radius, speed, rate, gain; most negative height
		load_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h00FFFFFF);
		for (int i = 0; i < 6; i++) send_pose(rand_pose());
		p = '{32'hFFFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
			16'sd16384, 16'sd0, 16'sd0, 16'sd0};
		send_pose(p);
		release_sample();
		drain();
		// Zero radius, speed, rate and gain, upper bits set above register widths; largest height
		load_config(32'h80000000, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'hFF000000);
		for (int i = 0; i < 4; i++) send_pose(rand_pose());
		release_sample();
		drain();

		// Random phases, each with its own settings; the last uses the reset defaults with no idles
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) begin
				sender_idle_on = 1'b0;
				receiver_idle_on = 1'b0;
				load_config(32'd393216, 32'd131072, 32'd890059, 32'd196608, 32'd6554);
			end else
				load_config($urandom & 32'h7FFFFFFF, $urandom_range(0, 1 << 22),
					$urandom, rand_wide(), ph[0] ? $urandom : $urandom_range(0, 1 << 17));
			for (int i = 0; i < N_RANDOM / 8; i++) send_pose(rand_pose());
			release_sample();
			drain();
		end

		$display("Covered %0d poses over %0d register settings, %0d commands checked.",
			poses_sent, config_sets, sb.checked);
		$display("Register extremes, quadrant crossings, saturation and raw quaternions hit.");
		if (sb.errors == 0 && sb.pending_cmds.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d commands outstanding", sb.pending_cmds.size());
		$display("end of test: mismatches");
		$finish;
	end
endmodule
